// File: hdl/rba_pkg.sv
// Shared types and constants of the reference-counted buffer slot allocator.
package rba_pkg;

    localparam int SLOTS_DEF       = 128;
    localparam int COUNT_WIDTH_DEF = 8;
    localparam int CHUNK           = 8;
    localparam int CHUNK_BITS      = 3;
    localparam int SLOT_W          = 7;
    localparam int ACTIVE_W        = 8;
    localparam int COUNT_OUT_W     = 8;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 8'd128;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_SHARE   = 2'd1,
        OP_DISCARD = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2,
        ST_SAT     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    typedef enum logic [1:0] {
        ALU_ONE,
        ALU_INC,
        ALU_DEC
    } t_alu_op;

    typedef struct packed {
        logic set_en;
        logic clr_en;
    } t_map_ctrl;

endpackage

// File: hdl/refcounted_buffer_slot_allocator_top.sv
// Top level of the reference-counted buffer slot allocator.
//
// Requests arrive on i_valid/o_stall with i_op and i_slot; one result per
// request leaves on o_valid/i_stall with slot, status, release flag and count.
// A transfer happens at a rising edge where valid is high and stall is low.
// The block handles one request at a time and raises o_stall while busy.
// For share, discard and the unused opcode, the transfer cycle issues the
// use-count memory read, and the next cycle updates and answers.
// Alloc searches the bitmap eight slots per cycle, one group of eight at a
// time over the lowest min(active, 128) slots, and stops at the first group
// with a free slot or after the last group.
// The result lands in an output register one cycle after the last work cycle,
// and the next request may be taken while that result waits. When the
// receiver stalls, a finished request waits in its last work cycle until the
// output register frees up. Synchronous reset clears the bitmap, sets the
// active slot count to 128 and empties the output register; use counts are
// not cleared, since every slot is written by alloc before it is read.
// The active_slots register is written through i_cfg_wr_en and i_cfg_wr_data;
// the user must do so only while the block is idle; the block does not enforce it.
module refcounted_buffer_slot_allocator_top import rba_pkg::*; #(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [ACTIVE_W-1:0]    i_cfg_wr_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_op,
    input  logic [SLOT_W-1:0]      i_slot,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [SLOT_W-1:0]      o_slot_out,
    output logic [1:0]             o_status,
    output logic                   o_released,
    output logic [COUNT_OUT_W-1:0] o_use_count_out
);

    localparam int SW     = $clog2(SLOTS);
    localparam int LW     = $clog2(SLOTS + 1);
    localparam int NCHUNK = (SLOTS + CHUNK - 1) / CHUNK;
    localparam int CKW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int IW     = CKW + CHUNK_BITS;
    localparam int CMPA   = (IW > LW) ? IW : LW;
    localparam int CMPW   = (CMPA > SLOT_W) ? CMPA : SLOT_W;
    localparam int NBW    = CMPW + 1;
    localparam int CLW    = (LW > ACTIVE_W) ? LW : ACTIVE_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    t_state                  r_state;
    t_state                  n_state;
    t_op                     r_op;
    logic [SLOT_W-1:0]       r_slot;
    logic [CKW-1:0]          r_chunk;
    logic [CKW-1:0]          n_chunk;
    logic [ACTIVE_W-1:0]     r_active;

    logic                    r_ovalid;
    logic [SLOT_W-1:0]       r_o_slot;
    t_status                 r_o_status;
    logic                    r_o_released;
    logic [COUNT_OUT_W-1:0]  r_o_count;

    logic                    in_xfer;
    logic                    out_free;
    logic [LW-1:0]           limit;
    logic                    found;
    logic [CHUNK_BITS-1:0]   off;
    logic                    busy;
    logic [IW-1:0]           grant;
    logic                    scan_end;
    logic                    slot_ok;

    t_map_ctrl               map_ctrl;
    logic [SW-1:0]           map_idx;
    logic                    ram_rd_en;
    logic                    ram_wr_en;
    logic [SW-1:0]           ram_wr_addr;
    logic [COUNT_WIDTH-1:0]  ram_rd_data;
    t_alu_op                 alu_op;
    logic [COUNT_WIDTH-1:0]  alu_count;
    logic                    alu_sat;
    logic                    alu_zero;

    logic                    load;
    logic [SLOT_W-1:0]       n_o_slot;
    t_status                 n_o_status;
    logic                    n_o_released;
    logic [COUNT_OUT_W-1:0]  n_o_count;

    assign o_stall  = (r_state != S_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    assign limit = (CLW'(r_active) < CLW'(SLOTS)) ? LW'(r_active) : LW'(SLOTS);

    assign grant    = {r_chunk, off};
    assign scan_end = (NBW'({r_chunk, CHUNK_BITS'(0)}) + NBW'(CHUNK)) >= NBW'(limit);
    assign slot_ok  = (CMPW'(r_slot) < CMPW'(limit)) && busy;

    rba_bitmap #(
        .SLOTS (SLOTS)
    ) u_bitmap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (map_ctrl),
        .i_wr_idx (map_idx),
        .i_chunk  (r_chunk),
        .i_limit  (limit),
        .i_rd_idx (SW'(r_slot)),
        .o_found  (found),
        .o_off    (off),
        .o_busy   (busy)
    );

    rba_cnt_ram #(
        .DEPTH (SLOTS),
        .WIDTH (COUNT_WIDTH)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (alu_count),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (SW'(i_slot)),
        .o_rd_data (ram_rd_data)
    );

    rba_cnt_alu #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cnt_alu (
        .i_op    (alu_op),
        .i_count (ram_rd_data),
        .o_count (alu_count),
        .o_sat   (alu_sat),
        .o_zero  (alu_zero)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= ACTIVE_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_active <= i_cfg_wr_data;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chunk <= n_chunk;
        if (in_xfer) begin
            r_op   <= t_op'(i_op);
            r_slot <= i_slot;
        end
        if (load) begin
            r_o_slot     <= n_o_slot;
            r_o_status   <= n_o_status;
            r_o_released <= n_o_released;
            r_o_count    <= n_o_count;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = (t_op'(i_op) == OP_ALLOC) ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                if ((found || scan_end) && out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_chunk      = r_chunk;
        ram_rd_en    = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = SW'(r_slot);
        map_ctrl     = '0;
        map_idx      = SW'(r_slot);
        alu_op       = ALU_ONE;
        load         = 1'b0;
        n_o_slot     = r_slot;
        n_o_status   = ST_OK;
        n_o_released = 1'b0;
        n_o_count    = '0;
        unique case (r_state)
            S_IDLE: begin
                n_chunk   = '0;
                ram_rd_en = in_xfer;
            end
            S_SCAN: begin
                alu_op = ALU_ONE;
                if (found) begin
                    if (out_free) begin
                        ram_wr_en       = 1'b1;
                        ram_wr_addr     = SW'(grant);
                        map_ctrl.set_en = 1'b1;
                        map_idx         = SW'(grant);
                        load            = 1'b1;
                        n_o_slot        = SLOT_W'(grant);
                        n_o_count       = COUNT_OUT_W'(alu_count);
                    end
                end else if (scan_end) begin
                    if (out_free) begin
                        load       = 1'b1;
                        n_o_slot   = '0;
                        n_o_status = ST_FULL;
                    end
                end else begin
                    n_chunk = CKW'(r_chunk + 1'b1);
                end
            end
            S_EXEC: begin
                alu_op = (r_op == OP_SHARE) ? ALU_INC : ALU_DEC;
                load   = out_free;
                if (r_op == OP_NOP) begin
                    n_o_status = ST_OK;
                end else if (!slot_ok) begin
                    n_o_status = ST_INVALID;
                end else if (r_op == OP_SHARE) begin
                    ram_wr_en  = out_free;
                    n_o_status = alu_sat ? ST_SAT : ST_OK;
                    n_o_count  = COUNT_OUT_W'(alu_sat ? COUNT_MAX : alu_count);
                end else begin
                    ram_wr_en       = out_free;
                    map_ctrl.clr_en = out_free && alu_zero;
                    n_o_released    = alu_zero;
                    n_o_count       = COUNT_OUT_W'(alu_count);
                end
            end
            default: begin
                n_chunk = '0;
            end
        endcase
    end

    assign o_valid         = r_ovalid;
    assign o_slot_out      = r_o_slot;
    assign o_status        = r_o_status;
    assign o_released      = r_o_released;
    assign o_use_count_out = r_o_count;

endmodule

// File: hdl/rba_cnt_ram.sv
// Use-count memory with one write port and one registered read port.
module rba_cnt_ram import rba_pkg::*; #(
    parameter int DEPTH = SLOTS_DEF,
    parameter int WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/rba_cnt_alu.sv
// Shared count unit: load one, saturating increment and floored decrement.
module rba_cnt_alu import rba_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  t_alu_op                i_op,
    input  logic [COUNT_WIDTH-1:0] i_count,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic                   o_sat,
    output logic                   o_zero
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    always_comb begin
        o_sat   = 1'b0;
        o_count = i_count;
        unique case (i_op)
            ALU_ONE: begin
                o_count = COUNT_WIDTH'(1);
            end
            ALU_INC: begin
                if (i_count == COUNT_MAX) begin
                    o_sat = 1'b1;
                end else begin
                    o_count = i_count + COUNT_WIDTH'(1);
                end
            end
            ALU_DEC: begin
                if (i_count != '0) begin
                    o_count = i_count - COUNT_WIDTH'(1);
                end
            end
            default: begin
                o_count = i_count;
            end
        endcase
        o_zero = (o_count == '0);
    end

endmodule

// File: hdl/rba_bitmap.sv
// Occupancy bitmap with a chunk-wide lowest-free-slot search.
module rba_bitmap import rba_pkg::*; #(
    parameter  int SLOTS  = SLOTS_DEF,
    localparam int SW     = $clog2(SLOTS),
    localparam int LW     = $clog2(SLOTS + 1),
    localparam int NCHUNK = (SLOTS + CHUNK - 1) / CHUNK,
    localparam int CKW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_map_ctrl                i_ctrl,
    input  logic [SW-1:0]            i_wr_idx,
    input  logic [CKW-1:0]           i_chunk,
    input  logic [LW-1:0]            i_limit,
    input  logic [SW-1:0]            i_rd_idx,
    output logic                     o_found,
    output logic [CHUNK_BITS-1:0]    o_off,
    output logic                     o_busy
);

    localparam int IW     = CKW + CHUNK_BITS;
    localparam int CMPW   = (IW > LW) ? IW : LW;

    logic [SLOTS-1:0]          r_occ;
    logic [NCHUNK*CHUNK-1:0]   occ_pad;
    logic [CHUNK-1:0]          row;
    logic [CHUNK-1:0]          free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_ctrl.set_en) begin
            r_occ[i_wr_idx] <= 1'b1;
        end else if (i_ctrl.clr_en) begin
            r_occ[i_wr_idx] <= 1'b0;
        end
    end

    always_comb begin
        occ_pad              = '1;
        occ_pad[SLOTS-1:0]   = r_occ;
    end

    assign row    = occ_pad[{i_chunk, CHUNK_BITS'(0)} +: CHUNK];
    assign o_busy = occ_pad[i_rd_idx];

    always_comb begin
        for (int j = 0; j < CHUNK; j++) begin
            free[j] = !row[j] &&
                      (CMPW'({i_chunk, CHUNK_BITS'(j)}) < CMPW'(i_limit));
        end
        o_found = 1'b0;
        o_off   = '0;
        for (int j = CHUNK - 1; j >= 0; j--) begin
            if (free[j]) begin
                o_found = 1'b1;
                o_off   = CHUNK_BITS'(j);
            end
        end
    end

endmodule

// File: hdl/rba_checker.sv
// Port-level checks of the allocator, bound to its top level.
module rba_checker import rba_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_cfg_wr_en,
    input logic [ACTIVE_W-1:0]    i_cfg_wr_data,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic [1:0]             i_op,
    input logic [SLOT_W-1:0]      i_slot,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic [SLOT_W-1:0]      o_slot_out,
    input logic [1:0]             o_status,
    input logic                   o_released,
    input logic [COUNT_OUT_W-1:0] o_use_count_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_slot_out) && $stable(o_status)
            && $stable(o_released) && $stable(o_use_count_out))
        else $error("Stalled result changed before its transfer.");

    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("Block accepted a request without going busy.");

    a_release_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_released |-> o_status == ST_OK && o_use_count_out == '0)
        else $error("Released slot reported with a nonzero count or error.");

    a_full_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_slot_out == '0 && o_use_count_out == '0
            && !o_released)
        else $error("Pool-full result carries a slot or a count.");

    a_invalid_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_INVALID |-> o_use_count_out == '0 && !o_released)
        else $error("Rejected request reports a count or a release.");

endmodule

bind refcounted_buffer_slot_allocator_top rba_checker u_rba_checker (.*);

// File: dv/refcounted_buffer_slot_allocator_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the reference-counted buffer slot allocator top level.
module refcounted_buffer_slot_allocator_top_test;
    import rba_pkg::*;

    localparam int SLOTS = SLOTS_DEF;
    localparam logic [COUNT_OUT_W-1:0] COUNT_MAX = 8'hFF;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        t_op                  op;
        logic [SLOT_W-1:0]    slot;
    } t_slot_req;

    typedef struct packed {
        logic [SLOT_W-1:0]      slot;
        t_status                status;
        logic                   released;
        logic [COUNT_OUT_W-1:0] count;
    } t_slot_reply;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [ACTIVE_W-1:0]    cfg_wr_data = '0;
    logic                   req_valid = 1'b0;
    t_op                    req_op = OP_NOP;
    logic [SLOT_W-1:0]      req_slot = '0;
    logic                   rsp_stall = 1'b0;
    logic                   rx_hold = 1'b0;
    logic                   hold_go = 1'b0;

    logic                   dut_stall;
    logic                   rsp_valid;
    logic [SLOT_W-1:0]      rsp_slot;
    logic [1:0]             rsp_status;
    logic                   rsp_released;
    logic [COUNT_OUT_W-1:0] rsp_count;

    logic                   slot_busy [SLOTS];
    logic [COUNT_OUT_W-1:0] use_cnt [SLOTS];
    logic [ACTIVE_W-1:0]    active_cfg = ACTIVE_RESET;

    t_slot_req              slot_requests [$];
    t_slot_reply            replies_due [$];
    t_slot_req              next_req;
    t_slot_req              taken_req;
    int unsigned            src_idle_pct = 36;
    int unsigned            dst_idle_pct = 36;
    int unsigned            mismatch_cnt = 0;
    int unsigned            cycle_cnt = 0;

    refcounted_buffer_slot_allocator_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_valid         (req_valid),
        .o_stall         (dut_stall),
        .i_op            (req_op),
        .i_slot          (req_slot),
        .o_valid         (rsp_valid),
        .i_stall         (rsp_stall),
        .o_slot_out      (rsp_slot),
        .o_status        (rsp_status),
        .o_released      (rsp_released),
        .o_use_count_out (rsp_count)
    );

    always #10 clk = ~clk;

    function automatic t_slot_reply update_pool(t_slot_req req);
        t_slot_reply res;
        int unsigned lim;
        logic        found;
        res.slot     = req.slot;
        res.status   = ST_OK;
        res.released = 1'b0;
        res.count    = '0;
        lim   = (active_cfg < SLOTS) ? active_cfg : SLOTS;
        found = 1'b0;
        case (req.op)
            OP_ALLOC: begin
                res.slot   = '0;
                res.status = ST_FULL;
                for (int i = 0; i < lim; i++) begin
                    if (!found && !slot_busy[i]) begin
                        found        = 1'b1;
                        slot_busy[i] = 1'b1;
                        use_cnt[i]   = 8'd1;
                        res.slot     = SLOT_W'(i);
                        res.status   = ST_OK;
                        res.count    = 8'd1;
                    end
                end
            end
            OP_NOP: begin
                res.status = ST_OK;
            end
            default: begin
                if (req.slot >= lim || !slot_busy[req.slot]) begin
                    res.status = ST_INVALID;
                end else if (req.op == OP_SHARE) begin
                    if (use_cnt[req.slot] == COUNT_MAX) begin
                        res.status = ST_SAT;
                        res.count  = COUNT_MAX;
                    end else begin
                        use_cnt[req.slot] = use_cnt[req.slot] + 8'd1;
                        res.count = use_cnt[req.slot];
                    end
                end else begin
                    if (use_cnt[req.slot] != 0)
                        use_cnt[req.slot] = use_cnt[req.slot] - 8'd1;
                    res.count = use_cnt[req.slot];
                    if (use_cnt[req.slot] == 0) begin
                        slot_busy[req.slot] = 1'b0;
                        res.released = 1'b1;
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic t_slot_req random_req();
        t_slot_req   r;
        int unsigned pick;
        int unsigned hi;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.op = OP_ALLOC;
        else if (pick < 65)
            r.op = OP_SHARE;
        else if (pick < 94)
            r.op = OP_DISCARD;
        else
            r.op = OP_NOP;
        hi = (active_cfg == 0) ? 1 : ((active_cfg > 24) ? 24 : active_cfg);
        if ($urandom_range(0, 99) < 15)
            r.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
        else
            r.slot = SLOT_W'($urandom_range(0, hi - 1));
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_cnt < 50)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic check_reply();
        t_slot_reply want;
        if (replies_due.size() == 0) begin
            report_mismatch("transfer out with no request outstanding");
            return;
        end
        want = replies_due.pop_front();
        if (rsp_slot !== want.slot)
            report_mismatch($sformatf("slot_out %0d, want %0d", rsp_slot, want.slot));
        if (rsp_status !== want.status)
            report_mismatch($sformatf("status %0d on slot %0d, want %0d",
                                      rsp_status, want.slot, want.status));
        if (rsp_released !== want.released)
            report_mismatch($sformatf("released %0b on slot %0d, want %0b",
                                      rsp_released, want.slot, want.released));
        if (rsp_count !== want.count)
            report_mismatch($sformatf("use count %0d on slot %0d, want %0d",
                                      rsp_count, want.slot, want.count));
    endtask

    task automatic push_req(t_op op, logic [SLOT_W-1:0] slot);
        t_slot_req r;
        r.op   = op;
        r.slot = slot;
        slot_requests.push_back(r);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (slot_requests.size() != 0 || req_valid || replies_due.size() != 0);
    endtask

    task automatic write_active(logic [ACTIVE_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        active_cfg  = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(logic [ACTIVE_W-1:0] value, int unsigned src_pct,
                             int unsigned dst_pct, int n);
        wait_drained();
        write_active(value);
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        repeat (n) slot_requests.push_back(random_req());
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || !dut_stall) begin
            if (req_valid) begin
                taken_req.op   = req_op;
                taken_req.slot = req_slot;
                replies_due.push_back(update_pool(taken_req));
            end
            if (slot_requests.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                next_req = slot_requests.pop_front();
                req_valid <= 1'b1;
                req_op    <= next_req.op;
                req_slot  <= next_req.slot;
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_stall <= 1'b0;
        end else begin
            if (rsp_valid && !rsp_stall)
                check_reply();
            rsp_stall <= rx_hold || ($urandom_range(0, 99) < dst_idle_pct);
        end
    end

    initial begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_slot_req         noise;
        logic [SLOT_W-1:0] sat_slot;
        for (int i = 0; i < SLOTS; i++) begin
            slot_busy[i] = 1'b0;
            use_cnt[i]   = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_active(8'd128);
        push_req(OP_ALLOC, 7'd0);
        push_req(OP_ALLOC, 7'd127);
        push_req(OP_ALLOC, 7'd5);
        push_req(OP_SHARE, 7'd0);
        push_req(OP_DISCARD, 7'd0);
        push_req(OP_DISCARD, 7'd0);
        push_req(OP_DISCARD, 7'd0);
        push_req(OP_SHARE, 7'd127);
        push_req(OP_DISCARD, 7'd127);
        push_req(OP_NOP, 7'd127);
        push_req(OP_NOP, 7'd0);
        push_req(OP_ALLOC, 7'd0);
        push_req(OP_SHARE, 7'd2);
        wait_drained();
        write_active(8'd1);
        push_req(OP_ALLOC, 7'd0);
        push_req(OP_SHARE, 7'd2);
        push_req(OP_DISCARD, 7'd1);
        push_req(OP_SHARE, 7'd0);
        wait_drained();
        write_active(8'd0);
        push_req(OP_ALLOC, 7'd0);
        push_req(OP_SHARE, 7'd0);
        push_req(OP_DISCARD, 7'd0);
        wait_drained();
        write_active(8'd255);
        push_req(OP_SHARE, 7'd2);
        push_req(OP_ALLOC, 7'd0);
        push_req(OP_DISCARD, 7'd1);
        push_req(OP_ALLOC, 7'd0);

        // Drive one slot up to the count ceiling and back down to release.
        wait_drained();
        write_active(8'd128);
        src_idle_pct = 20;
        dst_idle_pct = 20;
        sat_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!slot_busy[i])
                sat_slot = SLOT_W'(i);
        end
        push_req(OP_ALLOC, sat_slot);
        for (int k = 0; k < 512; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                noise = random_req();
                if (noise.slot == sat_slot)
                    noise.slot = noise.slot ^ 7'd1;
                slot_requests.push_back(noise);
            end
            push_req((k < 256) ? OP_SHARE : OP_DISCARD, sat_slot);
        end

        run_phase(8'd5, 36, 36, 120);
        run_phase(8'd255, 0, 0, 200);
        run_phase(8'd1, 36, 36, 50);
        run_phase(8'd0, 36, 36, 30);
        run_phase(8'd17, 36, 36, 120);
        run_phase(8'd64, 0, 36, 150);
        hold_go = 1'b1;
        run_phase(8'd9, 36, 36, 120);
        run_phase(8'd128, 36, 36, 120);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && replies_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
